[rtl/core/ias_pkg.sv]
package ias_pkg;

   localparam int IDX_W  = 12;
   localparam int DATA_W = 32;

   typedef enum logic [4:0] {
      ST_CLEAR  = 5'b00001,
      ST_IDLE   = 5'b00010,
      ST_LOOK   = 5'b00100,
      ST_LINK   = 5'b01000,
      ST_DECIDE = 5'b10000
   } state_type;

   typedef struct packed {
      logic clear_wr;
      logic capture;
      logic look;
      logic link;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic clear_done;
      logic out_free;
   } status_type;

endpackage

[rtl/core/ias_ram.sv]
module ias_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/ias_ctrl.sv]
module ias_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  ias_pkg::status_type status,
   output ias_pkg::cmd_type    cmd
);

   import ias_pkg::*;

   state_type state_ff;
   state_type state_in;
   logic      accept;

   assign req_stall = !((state_ff == ST_IDLE) ||
                        ((state_ff == ST_DECIDE) && status.out_free));
   assign accept    = req_valid && !req_stall;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      cmd.capture  = accept;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_wr = 1'b1;
            if (status.clear_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_LOOK;
            end
         end
         ST_LOOK: begin
            cmd.look = 1'b1;
            state_in = ST_LINK;
         end
         ST_LINK: begin
            cmd.link = 1'b1;
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (status.out_free) begin
               cmd.commit = 1'b1;
               state_in   = req_valid ? ST_LOOK : ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[rtl/core/ias_datapath.sv]
module ias_datapath #(
   parameter int ENTRIES    = 4096,
   parameter int BLOCK_BITS = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   input  ias_pkg::cmd_type                  cmd,
   output ias_pkg::status_type               status,
   input  logic                              req_action,
   input  logic [ias_pkg::IDX_W-1:0]         req_index,
   input  logic signed [ias_pkg::DATA_W-1:0] req_write_value,
   input  logic                              csr_write_enable,
   input  logic signed [ias_pkg::DATA_W-1:0] csr_write_data,
   input  logic                              rsp_stall,
   output logic                              rsp_valid,
   output logic signed [ias_pkg::DATA_W-1:0] rsp_read_data,
   output logic                              rsp_was_written
);

   import ias_pkg::*;

   localparam int BLOCKS   = (ENTRIES + BLOCK_BITS - 1) / BLOCK_BITS;
   localparam int BLK_W    = (BLOCKS > 1) ? $clog2(BLOCKS) : 1;
   localparam int COUNT_W  = $clog2(BLOCKS + 1);
   localparam int POS_W    = $clog2(BLOCK_BITS);
   localparam int ENTRY_W  = $clog2(ENTRIES);
   localparam int EXT_W    = (ENTRY_W > IDX_W) ? ENTRY_W : IDX_W;
   localparam int CMP_W    = EXT_W + 1;
   // block number by reciprocal multiply, exact for every IDX_W-bit index
   localparam int RECIP_SH = IDX_W + 6;
   localparam int RECIP    = ((1 << RECIP_SH) + BLOCK_BITS - 1) / BLOCK_BITS;
   localparam int RECIP_W  = RECIP_SH - 2;
   localparam int PROD_W   = IDX_W + RECIP_W;

   // captured word
   logic                     act_ff;
   logic [IDX_W-1:0]         idx_ff;
   logic signed [DATA_W-1:0] val_ff;
   logic [IDX_W-1:0]         blk_ff;
   logic [POS_W-1:0]         pos_ff;
   logic signed [DATA_W-1:0] default_value_ff;

   logic [COUNT_W-1:0]       count_ff;
   logic [BLK_W-1:0]         clr_ff;
   logic                     rsp_valid_ff;
   logic signed [DATA_W-1:0] rsp_read_data_ff;
   logic                     rsp_was_written_ff;

   logic [PROD_W-1:0]        quot_prod;
   logic [IDX_W-1:0]         blk_in;
   logic [IDX_W-1:0]         blk_base;
   logic [IDX_W-1:0]         rem;
   logic [EXT_W-1:0]         idx_ext;
   logic [ENTRY_W-1:0]       word_addr;
   logic [BLK_W-1:0]         blk_addr;
   logic                     in_range;
   logic                     live;
   logic                     had;
   logic [BLOCK_BITS-1:0]    bit_vec;
   logic                     wr_ok;
   logic                     push;
   logic                     out_free;

   logic [BLK_W-1:0]         link_rd;
   logic [BLK_W-1:0]         stack_rd;
   logic [BLOCK_BITS-1:0]    mask_rd;
   logic [DATA_W-1:0]        word_rd;

   logic                     link_we;
   logic [BLK_W-1:0]         link_wa;
   logic [BLK_W-1:0]         link_wd;
   logic                     mask_we;
   logic [BLOCK_BITS-1:0]    mask_wd;

   assign quot_prod = PROD_W'(idx_ff) * PROD_W'(RECIP);
   assign blk_in    = IDX_W'(quot_prod >> RECIP_SH);
   assign blk_base  = blk_ff * IDX_W'(BLOCK_BITS);
   assign rem       = idx_ff - blk_base;
   assign idx_ext   = EXT_W'(idx_ff);
   assign word_addr = idx_ext[ENTRY_W-1:0];
   assign blk_addr  = BLK_W'(blk_ff);
   assign in_range  = CMP_W'(idx_ff) < CMP_W'(ENTRIES);

   assign live    = in_range && (COUNT_W'(link_rd) < count_ff) && (stack_rd == blk_addr);
   assign had     = live && mask_rd[pos_ff];
   assign bit_vec = BLOCK_BITS'(1) << pos_ff;
   assign wr_ok   = cmd.commit && act_ff && in_range;
   assign push    = wr_ok && !live && (count_ff < COUNT_W'(BLOCKS));

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign status.out_free   = out_free;
   assign status.clear_done = (clr_ff == BLK_W'(BLOCKS - 1));

   assign link_we = cmd.clear_wr || push;
   assign link_wa = cmd.clear_wr ? clr_ff : blk_addr;
   assign link_wd = cmd.clear_wr ? '0 : BLK_W'(count_ff);
   assign mask_we = wr_ok && (live || push);
   assign mask_wd = live ? (mask_rd | bit_vec) : bit_vec;

   ias_ram #(.WIDTH(BLK_W), .DEPTH(BLOCKS)) u_link_ram (
      .clock   (clock),
      .wr_en   (link_we),
      .wr_addr (link_wa),
      .wr_data (link_wd),
      .rd_en   (cmd.look),
      .rd_addr (BLK_W'(blk_in)),
      .rd_data (link_rd)
   );

   ias_ram #(.WIDTH(BLK_W), .DEPTH(BLOCKS)) u_stack_ram (
      .clock   (clock),
      .wr_en   (push),
      .wr_addr (BLK_W'(count_ff)),
      .wr_data (blk_addr),
      .rd_en   (cmd.link),
      .rd_addr (link_rd),
      .rd_data (stack_rd)
   );

   ias_ram #(.WIDTH(BLOCK_BITS), .DEPTH(BLOCKS)) u_mask_ram (
      .clock   (clock),
      .wr_en   (mask_we),
      .wr_addr (blk_addr),
      .wr_data (mask_wd),
      .rd_en   (cmd.link),
      .rd_addr (blk_addr),
      .rd_data (mask_rd)
   );

   ias_ram #(.WIDTH(DATA_W), .DEPTH(ENTRIES)) u_word_ram (
      .clock   (clock),
      .wr_en   (mask_we),
      .wr_addr (word_addr),
      .wr_data (DATA_W'(val_ff)),
      .rd_en   (cmd.look),
      .rd_addr (word_addr),
      .rd_data (word_rd)
   );

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         act_ff <= req_action;
         idx_ff <= req_index;
         val_ff <= req_write_value;
      end
      if (cmd.look) begin
         blk_ff <= blk_in;
      end
      if (cmd.link) begin
         pos_ff <= POS_W'(rem);
      end
      if (cmd.commit) begin
         rsp_was_written_ff <= had;
         if (act_ff) begin
            rsp_read_data_ff <= val_ff;
         end else if (had) begin
            rsp_read_data_ff <= $signed(word_rd);
         end else begin
            rsp_read_data_ff <= default_value_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         default_value_ff <= '0;
         count_ff         <= '0;
         clr_ff           <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            default_value_ff <= csr_write_data;
         end
         if (push) begin
            count_ff <= count_ff + COUNT_W'(1);
         end
         if (cmd.clear_wr && !status.clear_done) begin
            clr_ff <= clr_ff + BLK_W'(1);
         end
         if (cmd.commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_read_data   = rsp_read_data_ff;
   assign rsp_was_written = rsp_was_written_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(BLOCKS))
      else $error("live block count beyond block total");

   a_count_on_commit: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && (count_ff != $past(count_ff)) |-> $past(cmd.commit))
      else $error("live block count moved without a commit");

   a_commit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> out_free)
      else $error("commit while output word still held");

   a_commit_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_valid_ff)
      else $error("commit did not present a word");
`endif

endmodule

[rtl/core/initializable_array_store.sv]
// Initializable array store: ENTRIES signed 32-bit words that read as the
// default value until written, with no clear of the word store.
// Request channel (req_valid / req_stall): req_action 0 reads, 1 writes
// req_index; req_write_value is stored on a write.
// Response channel (rsp_valid / rsp_stall): one word per request.
// rsp_read_data is the entry or the default on a read, the written value
// on a write; rsp_was_written tells whether the entry held a write before.
// csr_write_enable / csr_write_data load the default value (reset 0).
// Each request is worked through the LOOK, LINK and DECIDE states: the
// chained registered reads of back-link, then stack slot and mask, then
// write-back; the next request is taken only as the last one commits.
// Reset: synchronous; after it a clearing pass writes every entry of the
// back-link memory, one entry a cycle (BLOCKS entries, 64 at default sizes),
// with req_stall high. Config writes are taken at any time.
// When rsp_stall holds a response, one more request is worked up to its
// final cycle and then waits; req_stall stays high until the output frees.
module initializable_array_store #(
   parameter int ENTRIES    = 4096,
   parameter int BLOCK_BITS = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_action,
   input  logic [ias_pkg::IDX_W-1:0]         req_index,
   input  logic signed [ias_pkg::DATA_W-1:0] req_write_value,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [ias_pkg::DATA_W-1:0] rsp_read_data,
   output logic                              rsp_was_written,
   input  logic                              csr_write_enable,
   input  logic signed [ias_pkg::DATA_W-1:0] csr_write_data
);

   import ias_pkg::*;

   cmd_type    cmd;
   status_type status;

   ias_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   ias_datapath #(
      .ENTRIES    (ENTRIES),
      .BLOCK_BITS (BLOCK_BITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_action       (req_action),
      .req_index        (req_index),
      .req_write_value  (req_write_value),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .rsp_stall        (rsp_stall),
      .rsp_valid        (rsp_valid),
      .rsp_read_data    (rsp_read_data),
      .rsp_was_written  (rsp_was_written)
   );

endmodule
